>>> rtl/core/ibba_pkg.sv
// ----------------------------------------------------------------------------
// ibba_pkg: shared types and codes for the bitmap allocator
// Request and response payloads, function and status codes, register indexes
// and the lowest-clear-bit search used by the word scan.
// ----------------------------------------------------------------------------
package ibba_pkg;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // default map sizes in bits
    localparam int DEF_INODE_MAP_BITS = 1024;
    localparam int DEF_BLOCK_MAP_BITS = 4096;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // request function codes
    localparam logic [1:0] FN_ALLOC_INODE = 2'd0;
    localparam logic [1:0] FN_FREE_INODE  = 2'd1;
    localparam logic [1:0] FN_ALLOC_BLOCK = 2'd2;
    localparam logic [1:0] FN_FREE_BLOCK  = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_TOTAL = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] item_number;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_number;
    } rsp_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } zero_hit_t;

    // lowest clear bit of one bitmap word
    function automatic zero_hit_t lowest_zero(input logic [WORD_BITS-1:0] w);
        zero_hit_t h;
        h = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!w[j]) begin
                h.found = 1'b1;
                h.pos   = BIT_W'(j);
            end
        end
        return h;
    endfunction

endpackage

>>> rtl/core/ibba_map.sv
// ----------------------------------------------------------------------------
// ibba_map: one allocation bitmap
// Single-port-write, single-port-read word RAM with a registered read.
// ----------------------------------------------------------------------------
module ibba_map #(
    parameter int WORDS = 32
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(WORDS)-1:0]       wr_addr,
    input  logic [ibba_pkg::WORD_BITS-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(WORDS)-1:0]       rd_addr,
    output logic [ibba_pkg::WORD_BITS-1:0] rd_data
);
    import ibba_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/inode_and_block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// inode_and_block_bitmap_allocator_unit: inode and data-block allocator
// First-fit allocation and range-checked free over two bitmap RAMs.
// ----------------------------------------------------------------------------
// One request at a time. After reset the unit clears both bitmaps, one word
// per cycle for the larger map, and holds s_ready low until that pass is
// done. An allocation reads its bitmap one 32-bit word per cycle through the
// single read port of that RAM, up to the first clear bit, reading at most
// 128 words with the default block map, 32 for inodes. Each result then
// waits in the output register until taken, and the next request is
// accepted after that.
module inode_and_block_bitmap_allocator_unit #(
    parameter int INODE_MAP_BITS = ibba_pkg::DEF_INODE_MAP_BITS,
    parameter int BLOCK_MAP_BITS = ibba_pkg::DEF_BLOCK_MAP_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ibba_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [ibba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ibba_pkg::req_t                  s_req,
    // response channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output ibba_pkg::rsp_t                  m_rsp
);
    import ibba_pkg::*;

    localparam int INODE_WORDS = (INODE_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BLOCK_WORDS = (BLOCK_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAX_WORDS   = (INODE_WORDS > BLOCK_WORDS) ? INODE_WORDS : BLOCK_WORDS;
    localparam int SAW         = $clog2(MAX_WORDS);
    localparam int IWA         = $clog2(INODE_WORDS);
    localparam int BWA         = $clog2(BLOCK_WORDS);
    localparam int IDXW        = SAW + BIT_W;
    localparam int ILW         = $clog2(INODE_MAP_BITS);
    localparam int BCW         = $clog2(BLOCK_MAP_BITS + 1);
    localparam int INODE_MAX   = INODE_MAP_BITS - 1;

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_FWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_WAIT = 3'd7;

    // configuration registers
    logic [9:0]  inode_count_reg;
    logic [31:0] first_data_reg;
    logic [31:0] block_total_reg;

    // control state
    logic [2:0]     state_reg, state_next;
    logic [SAW-1:0] clr_reg, clr_next;
    logic           dat_vld_reg, dat_vld_next;
    logic           m_valid_reg, m_valid_next;

    // request context
    logic [1:0]      func_reg, func_next;
    logic [31:0]     num_reg, num_next;
    logic            map_sel_reg, map_sel_next;
    logic [ILW-1:0]  ilim_reg, ilim_next;
    logic [BCW-1:0]  dcnt_reg, dcnt_next;
    logic [SAW-1:0]  iss_addr_reg, iss_addr_next;
    logic [SAW-1:0]  dat_addr_reg, dat_addr_next;
    logic [SAW-1:0]  last_reg, last_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic [1:0]      status_reg, status_next;
    rsp_t            rsp_reg, rsp_next;

    // ram controls
    logic                 rd_ino_en, rd_blk_en, wr_ino_en, wr_blk_en;
    logic [SAW-1:0]       rd_addr_c, wr_addr_c;
    logic [WORD_BITS-1:0] wr_data_c;
    logic [WORD_BITS-1:0] ino_rd, blk_rd, rdw;

    // derived values
    logic [ILW-1:0]       ilim_c;
    logic [BCW-1:0]       dcnt_c;
    logic [BCW-1:0]       dcnt_m1;
    logic [31:0]          diff_c, num_off_c;
    logic                 ino_bad, blk_bad;
    logic [WORD_BITS-1:0] busy;
    logic [IDXW-1:0]      gidx;
    logic [WORD_BITS-1:0] set_word;
    zero_hit_t            hit;

    // bitmap rams
    ibba_map #(.WORDS(INODE_WORDS)) u_inode_map (
        .aclk    (aclk),
        .wr_en   (wr_ino_en),
        .wr_addr (wr_addr_c[IWA-1:0]),
        .wr_data (wr_data_c),
        .rd_en   (rd_ino_en),
        .rd_addr (rd_addr_c[IWA-1:0]),
        .rd_data (ino_rd)
    );

    ibba_map #(.WORDS(BLOCK_WORDS)) u_block_map (
        .aclk    (aclk),
        .wr_en   (wr_blk_en),
        .wr_addr (wr_addr_c[BWA-1:0]),
        .wr_data (wr_data_c),
        .rd_en   (rd_blk_en),
        .rd_addr (rd_addr_c[BWA-1:0]),
        .rd_data (blk_rd)
    );

    assign rdw = map_sel_reg ? blk_rd : ino_rd;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_count_reg <= 10'd1023;
            first_data_reg  <= 32'd0;
            block_total_reg <= 32'd4096;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_INODE_COUNT: inode_count_reg <= cfg_wr_data[9:0];
                REG_FIRST_DATA:  first_data_reg  <= cfg_wr_data;
                REG_BLOCK_TOTAL: block_total_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // usable inode limit and managed data-block count
    always_comb begin
        if (32'(inode_count_reg) > 32'(INODE_MAX)) begin
            ilim_c = ILW'(INODE_MAX);
        end else begin
            ilim_c = ILW'(inode_count_reg);
        end
        diff_c = block_total_reg - first_data_reg;
        if (block_total_reg <= first_data_reg) begin
            dcnt_c = '0;
        end else if (diff_c > 32'(BLOCK_MAP_BITS)) begin
            dcnt_c = BCW'(BLOCK_MAP_BITS);
        end else begin
            dcnt_c = BCW'(diff_c);
        end
    end

    // free range checks on the latched request
    always_comb begin
        num_off_c = num_reg - first_data_reg;
        ino_bad   = (num_reg == 32'd0) || (num_reg > 32'(ilim_reg));
        blk_bad   = (num_reg < first_data_reg) || (num_reg >= block_total_reg) ||
                    (num_off_c >= 32'(dcnt_reg));
        dcnt_m1   = dcnt_reg - BCW'(1);
    end

    // mark out-of-range bits as taken, then find the lowest clear bit
    always_comb begin
        busy = '0;
        gidx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            gidx = {dat_addr_reg, BIT_W'(j)};
            if (map_sel_reg) begin
                busy[j] = rdw[j] | (32'(gidx) >= 32'(dcnt_reg));
            end else begin
                busy[j] = rdw[j] | (gidx == '0) | (32'(gidx) > 32'(ilim_reg));
            end
        end
        hit      = lowest_zero(busy);
        set_word = rdw | (WORD_BITS'(1) << hit.pos);
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        dat_vld_next  = dat_vld_reg;
        m_valid_next  = m_valid_reg;
        func_next     = func_reg;
        num_next      = num_reg;
        map_sel_next  = map_sel_reg;
        ilim_next     = ilim_reg;
        dcnt_next     = dcnt_reg;
        iss_addr_next = iss_addr_reg;
        dat_addr_next = dat_addr_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        rsp_next      = rsp_reg;
        rd_ino_en     = 1'b0;
        rd_blk_en     = 1'b0;
        rd_addr_c     = iss_addr_reg;
        wr_ino_en     = 1'b0;
        wr_blk_en     = 1'b0;
        wr_addr_c     = '0;
        wr_data_c     = '0;
        case (state_reg)
            // clearing pass over both maps
            S_CLR: begin
                wr_addr_c = clr_reg;
                wr_ino_en = 32'(clr_reg) < 32'(INODE_WORDS);
                wr_blk_en = 32'(clr_reg) < 32'(BLOCK_WORDS);
                if (clr_reg == SAW'(MAX_WORDS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + SAW'(1);
                end
            end
            // latch the request and the current limits
            S_IDLE: begin
                if (s_valid) begin
                    func_next    = s_req.func;
                    num_next     = s_req.item_number;
                    map_sel_next = (s_req.func == FN_ALLOC_BLOCK) ||
                                   (s_req.func == FN_FREE_BLOCK);
                    ilim_next    = ilim_c;
                    dcnt_next    = dcnt_c;
                    state_next   = S_PREP;
                end
            end
            // dispatch: set up the scan or check the free; no data blocks means no space
            S_PREP: begin
                iss_addr_next = '0;
                dat_vld_next  = 1'b0;
                case (func_reg)
                    FN_ALLOC_INODE: begin
                        last_next  = SAW'(ilim_reg >> BIT_W);
                        state_next = S_SCAN;
                    end
                    FN_ALLOC_BLOCK: begin
                        last_next = SAW'(dcnt_m1 >> BIT_W);
                        if (dcnt_reg == '0) begin
                            status_next = ST_NOSPACE;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    FN_FREE_INODE: begin
                        idx_next = IDXW'(num_reg);
                        if (ino_bad) begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_FRD;
                        end
                    end
                    default: begin
                        idx_next = IDXW'(num_off_c);
                        if (blk_bad) begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_FRD;
                        end
                    end
                endcase
            end
            // one word read per cycle, test the word read last cycle
            S_SCAN: begin
                rd_ino_en     = !map_sel_reg;
                rd_blk_en     = map_sel_reg;
                rd_addr_c     = iss_addr_reg;
                dat_addr_next = iss_addr_reg;
                dat_vld_next  = 1'b1;
                if (iss_addr_reg != last_reg) begin
                    iss_addr_next = iss_addr_reg + SAW'(1);
                end
                if (dat_vld_reg) begin
                    if (hit.found) begin
                        wr_ino_en   = !map_sel_reg;
                        wr_blk_en   = map_sel_reg;
                        wr_addr_c   = dat_addr_reg;
                        wr_data_c   = set_word;
                        idx_next    = {dat_addr_reg, hit.pos};
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end else if (dat_addr_reg == last_reg) begin
                        status_next = ST_NOSPACE;
                        state_next  = S_DONE;
                    end
                end
            end
            // free: read the word holding the bit
            S_FRD: begin
                rd_ino_en  = !map_sel_reg;
                rd_blk_en  = map_sel_reg;
                rd_addr_c  = idx_reg[IDXW-1:BIT_W];
                state_next = S_FWR;
            end
            // free: write it back with the bit cleared
            S_FWR: begin
                wr_ino_en   = !map_sel_reg;
                wr_blk_en   = map_sel_reg;
                wr_addr_c   = idx_reg[IDXW-1:BIT_W];
                wr_data_c   = rdw & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            // build the response
            S_DONE: begin
                rsp_next.status = status_reg;
                if (status_reg == ST_OK && func_reg == FN_ALLOC_BLOCK) begin
                    rsp_next.granted_number = first_data_reg + 32'(idx_reg);
                end else if (status_reg == ST_OK && func_reg == FN_ALLOC_INODE) begin
                    rsp_next.granted_number = 32'(idx_reg);
                end else begin
                    rsp_next.granted_number = '0;
                end
                m_valid_next = 1'b1;
                state_next   = S_WAIT;
            end
            // hold the response until taken
            S_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            dat_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            dat_vld_reg <= dat_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request context and response payload
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        num_reg      <= num_next;
        map_sel_reg  <= map_sel_next;
        ilim_reg     <= ilim_next;
        dcnt_reg     <= dcnt_next;
        iss_addr_reg <= iss_addr_next;
        dat_addr_reg <= dat_addr_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

`ifndef ASSERT_OFF
    // a new request is never taken while a response is pending
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request accepted while response pending");

    // accepting a request drops ready and starts work
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && !m_valid))
        else $error("ready held after accepting a request");

    // failed requests grant nothing
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status != ST_OK) |-> (m_rsp.granted_number == 32'd0))
        else $error("nonzero grant on failed request");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == ST_OK || m_rsp.status == ST_INVALID ||
                     m_rsp.status == ST_NOSPACE))
        else $error("undefined status code");
`endif

endmodule

>>> dv/ibba_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibba_alloc_checker: response checker for the bitmap allocator
// Watches the register writes and both channels, keeps its own inode and
// block bitmaps, works out the response of each accepted request and
// compares it field by field with the responses the unit returns, in order.
// ----------------------------------------------------------------------------
module ibba_alloc_checker #(
    parameter int INODE_MAP_BITS = ibba_pkg::DEF_INODE_MAP_BITS,
    parameter int BLOCK_MAP_BITS = ibba_pkg::DEF_BLOCK_MAP_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ibba_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [ibba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ibba_pkg::req_t                  s_req,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ibba_pkg::rsp_t                  m_rsp,
    output int                              fail_count,
    output int                              outstanding
);
    import ibba_pkg::*;

    // register values after reset
    localparam logic [9:0]  RESET_INODE_COUNT = 10'd1023;
    localparam logic [31:0] RESET_FIRST_DATA  = 32'd0;
    localparam logic [31:0] RESET_BLOCK_TOTAL = 32'd4096;

    typedef struct packed {
        req_t req;
        rsp_t rsp;
    } due_entry_t;

    // shadow bitmaps and registers
    logic [INODE_MAP_BITS-1:0] inode_used;
    logic [BLOCK_MAP_BITS-1:0] block_used;
    logic [9:0]                inode_count_q;
    logic [31:0]               first_data_q;
    logic [31:0]               block_total_q;

    // responses owed by the unit, oldest first
    due_entry_t due_responses[$];

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // highest inode number that can be handed out or freed
    function automatic logic [31:0] inode_limit();
        logic [31:0] lim;
        lim = {22'd0, inode_count_q};
        if (lim > 32'(INODE_MAP_BITS - 1))
            lim = 32'(INODE_MAP_BITS - 1);
        return lim;
    endfunction

    // data blocks under management, capped at the map size
    function automatic logic [31:0] managed_blocks();
        logic [31:0] n;
        if (block_total_q <= first_data_q)
            return 32'd0;
        n = block_total_q - first_data_q;
        if (n > 32'(BLOCK_MAP_BITS))
            n = 32'(BLOCK_MAP_BITS);
        return n;
    endfunction

    // apply one request to the shadow maps and return its response
    function automatic rsp_t serve_request(input req_t r);
        rsp_t        rsp;
        logic [31:0] lim;
        logic [31:0] offset;
        logic        hit;
        rsp.status         = ST_OK;
        rsp.granted_number = '0;
        hit                = 1'b0;
        case (r.func)
            FN_ALLOC_INODE: begin
                // first fit from inode one upward
                lim = inode_limit();
                for (int n = 1; n <= int'(lim); n++) begin
                    if (!hit && !inode_used[n]) begin
                        inode_used[n]      = 1'b1;
                        rsp.granted_number = 32'(n);
                        hit                = 1'b1;
                    end
                end
                if (!hit)
                    rsp.status = ST_NOSPACE;
            end
            FN_FREE_INODE: begin
                if (r.item_number == 32'd0 || r.item_number > inode_limit())
                    rsp.status = ST_INVALID;
                else
                    inode_used[r.item_number] = 1'b0;
            end
            FN_ALLOC_BLOCK: begin
                // first fit over the data-block indices
                lim = managed_blocks();
                for (int i = 0; i < int'(lim); i++) begin
                    if (!hit && !block_used[i]) begin
                        block_used[i]      = 1'b1;
                        rsp.granted_number = first_data_q + 32'(i);
                        hit                = 1'b1;
                    end
                end
                if (!hit)
                    rsp.status = ST_NOSPACE;
            end
            FN_FREE_BLOCK: begin
                offset = r.item_number - first_data_q;
                if (r.item_number < first_data_q || r.item_number >= block_total_q ||
                    offset >= managed_blocks())
                    rsp.status = ST_INVALID;
                else
                    block_used[offset] = 1'b0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // track writes, requests and responses at each edge
    always @(posedge aclk) begin : track
        due_entry_t due;
        if (!aresetn) begin
            inode_used    = '0;
            block_used    = '0;
            inode_count_q = RESET_INODE_COUNT;
            first_data_q  = RESET_FIRST_DATA;
            block_total_q = RESET_BLOCK_TOTAL;
            due_responses.delete();
            fail_count    = 0;
            outstanding  <= 0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_INODE_COUNT: inode_count_q = cfg_wr_data[9:0];
                    REG_FIRST_DATA:  first_data_q  = cfg_wr_data;
                    REG_BLOCK_TOTAL: block_total_q = cfg_wr_data;
                    default: ;
                endcase
            end

            // accepted request
            if (s_valid && s_ready) begin
                due.req = s_req;
                due.rsp = serve_request(s_req);
                due_responses.push_back(due);
            end

            // accepted response
            if (m_valid && m_ready) begin
                if (due_responses.size() == 0) begin
                    report_mismatch($sformatf(
                        "response with no request pending: status %0d number 0x%08h",
                        m_rsp.status, m_rsp.granted_number));
                end else begin
                    due = due_responses.pop_front();
                    if (m_rsp.status !== due.rsp.status)
                        report_mismatch($sformatf(
                            "func %0d num 0x%08h: status %0d expected %0d",
                            due.req.func, due.req.item_number, m_rsp.status,
                            due.rsp.status));
                    if (m_rsp.granted_number !== due.rsp.granted_number)
                        report_mismatch($sformatf(
                            "func %0d num 0x%08h: granted 0x%08h expected 0x%08h",
                            due.req.func, due.req.item_number, m_rsp.granted_number,
                            due.rsp.granted_number));
                end
            end

            outstanding <= due_responses.size();
        end
    end

endmodule

>>> dv/tb_inode_and_block_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inode_and_block_bitmap_allocator_unit: allocator unit testbench
// Directed allocate and free requests over the range edges of both maps,
// then random requests under random register settings, with the request
// side idling and the response side stalling in several phases.
// ----------------------------------------------------------------------------
module tb_inode_and_block_bitmap_allocator_unit;
    import ibba_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 150;
    localparam int ROUNDS_PER_PHASE = 4;
    localparam int REQS_PER_ROUND   = 34;
    localparam int PHASE_COUNT      = 4;
    localparam logic [31:0] BLOCK_SPAN_CAP = 32'(DEF_BLOCK_MAP_BITS + 1);

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    req_t                  s_req        = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    rsp_t                  m_rsp;
    int                    fail_count;
    int                    outstanding;

    // idle and stall rates in percent
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // register values last written, to aim free numbers at the live ranges
    logic [9:0]  cur_inode_count = 10'd1023;
    logic [31:0] cur_first_data  = 32'd0;
    logic [31:0] cur_block_total = 32'd4096;

    always #HALF_PERIOD aclk = ~aclk;

    inode_and_block_bitmap_allocator_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req        (s_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rsp        (m_rsp)
    );

    ibba_alloc_checker u_alloc_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req        (s_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rsp        (m_rsp),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // response side stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one request; valid stays high afterwards unless a gap follows
    task automatic send_request(input logic [1:0] func, input logic [31:0] number);
        req_t r;
        r.func        = func;
        r.item_number = number;
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait for every owed response
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // write all three registers on back-to-back cycles
    task automatic program_registers(input logic [31:0] inode_data,
                                     input logic [31:0] first_data,
                                     input logic [31:0] block_total);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_INODE_COUNT;
        cfg_wr_data  <= inode_data;
        @(posedge aclk);
        cfg_wr_index <= REG_FIRST_DATA;
        cfg_wr_data  <= first_data;
        @(posedge aclk);
        cfg_wr_index <= REG_BLOCK_TOTAL;
        cfg_wr_data  <= block_total;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        cur_inode_count  = inode_data[9:0];
        cur_first_data   = first_data;
        cur_block_total  = block_total;
    endtask

    // mostly small ranges so the maps fill up and empty again
    task automatic random_registers();
        logic [31:0] inode_data;
        logic [31:0] first_data;
        logic [31:0] block_total;
        inode_data = ($urandom_range(3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 40);
        if ($urandom_range(9) == 0)
            inode_data = 32'd0;
        if ($urandom_range(3) == 0)
            inode_data = inode_data | ($urandom & 32'hFFFF_FC00);
        case ($urandom_range(3))
            0:       first_data = 32'd0;
            1:       first_data = $urandom;
            2:       first_data = $urandom_range(0, 4000);
            default: first_data = 32'hFFFF_FFFF - $urandom_range(0, 60);
        endcase
        case ($urandom_range(7))
            0:       block_total = first_data + $urandom_range(4096, 5000);
            1:       block_total = first_data;
            2:       block_total = first_data - $urandom_range(1, 100);
            default: block_total = first_data + $urandom_range(1, 40);
        endcase
        program_registers(inode_data, first_data, block_total);
    endtask

    // random request, frees aimed mostly around the live ranges
    task automatic random_request();
        int unsigned pick;
        logic [31:0] number;
        logic [31:0] span;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_request(FN_ALLOC_INODE, $urandom);
        end else if (pick < 55) begin
            send_request(FN_ALLOC_BLOCK, $urandom);
        end else if (pick < 78) begin
            number = ($urandom_range(5) == 0) ? $urandom
                                              : $urandom_range(0, cur_inode_count + 1);
            send_request(FN_FREE_INODE, number);
        end else begin
            if (cur_block_total > cur_first_data) begin
                span = cur_block_total - cur_first_data;
                if (span > BLOCK_SPAN_CAP)
                    span = BLOCK_SPAN_CAP;
            end else begin
                span = 32'd3;
            end
            number = ($urandom_range(5) == 0) ? $urandom
                                              : cur_first_data - 1 + $urandom_range(0, span + 1);
            send_request(FN_FREE_BLOCK, number);
        end
    endtask

    // no-progress watchdog
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_inode_and_block_bitmap_allocator_unit NOT OK");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // default ranges: inode zero, double free, range edges
        program_registers(32'd1023, 32'd0, 32'd4096);
        send_request(FN_FREE_INODE, 32'd0);
        send_request(FN_ALLOC_INODE, 32'hFFFF_FFFF);
        send_request(FN_ALLOC_INODE, 32'd0);
        send_request(FN_FREE_INODE, 32'd1);
        send_request(FN_FREE_INODE, 32'd1);
        send_request(FN_ALLOC_INODE, 32'd0);
        send_request(FN_FREE_INODE, 32'd1023);
        send_request(FN_FREE_INODE, 32'd1024);
        send_request(FN_FREE_INODE, 32'hFFFF_FFFF);
        send_request(FN_ALLOC_BLOCK, 32'hFFFF_FFFF);
        send_request(FN_FREE_BLOCK, 32'd4095);
        send_request(FN_FREE_BLOCK, 32'd4096);
        send_request(FN_FREE_BLOCK, 32'd0);

        // one inode, data blocks at the top of the number space
        drain();
        program_registers(32'hFFFF_FC01, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_request(FN_ALLOC_INODE, 32'd0);
        send_request(FN_FREE_INODE, 32'd2);
        send_request(FN_ALLOC_BLOCK, 32'd0);
        send_request(FN_FREE_BLOCK, 32'hFFFF_FFEF);
        send_request(FN_FREE_BLOCK, 32'hFFFF_FFFF);
        send_request(FN_FREE_BLOCK, 32'hFFFF_FFFE);

        // no inodes, total below the data start
        drain();
        program_registers(32'd0, 32'd100, 32'd50);
        send_request(FN_ALLOC_INODE, 32'd0);
        send_request(FN_FREE_INODE, 32'd1);
        send_request(FN_ALLOC_BLOCK, 32'd0);
        send_request(FN_FREE_BLOCK, 32'd100);

        // data count cut to the map size
        drain();
        program_registers(32'd1023, 32'd0, 32'hFFFF_FFFF);
        send_request(FN_FREE_BLOCK, 32'd4096);
        send_request(FN_ALLOC_INODE, 32'd0);

        // random phases with different idle and stall rates
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            for (int round = 0; round < ROUNDS_PER_PHASE; round++) begin
                drain();
                random_registers();
                repeat (REQS_PER_ROUND) random_request();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_inode_and_block_bitmap_allocator_unit OK");
        else
            $display("tb_inode_and_block_bitmap_allocator_unit NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/core/ibba_pkg.sv
rtl/core/ibba_map.sv
rtl/core/inode_and_block_bitmap_allocator_unit.sv
dv/ibba_alloc_checker.sv
dv/tb_inode_and_block_bitmap_allocator_unit.sv
